[rtl/core/pbfs_pkg.sv]
// Package for the protobuf field scanner: types, codes, widths and helpers.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package pbfs_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int OFF_W       = OFFSET_BITS;
    localparam int OUT_OFF_W   = 16;
    localparam int KEY_W       = 64;
    localparam int FNUM_W      = 61;
    localparam int WT_W        = 3;
    localparam int VAL_W       = 64;
    localparam int ST_W        = 2;
    localparam int SHIFT_W     = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 160;
    localparam int OUT_TUSER_W = WT_W + ST_W;

    localparam logic [OFF_W-1:0]   OFF_MAX        = {OFF_W{1'b1}};
    localparam logic [SHIFT_W-1:0] VARINT_GROUPS  = 4'd10;
    localparam logic [7:0]         MORE_MASK      = 8'h80;
    localparam logic [7:0]         GROUP_MASK     = 8'h7f;
    localparam logic [KEY_W-1:0]   WT_MASK        = 64'h7;
    localparam logic [VAL_W-1:0]   FIX64_BYTES    = 64'd8;
    localparam logic [VAL_W-1:0]   FIX32_BYTES    = 64'd4;

    typedef enum logic [2:0] {
        PH_KEY,
        PH_VAL,
        PH_FIX,
        PH_LEN,
        PH_SKIP
    } t_phase;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_TRUNC  = 2'd1,
        ST_UNSUP  = 2'd2
    } t_status;

    localparam logic [WT_W-1:0] WT_VARINT = 3'd0;
    localparam logic [WT_W-1:0] WT_FIX64  = 3'd1;
    localparam logic [WT_W-1:0] WT_LEN    = 3'd2;
    localparam logic [WT_W-1:0] WT_FIX32  = 3'd5;

    typedef struct packed {
        logic [FNUM_W-1:0]    field_number;
        logic [WT_W-1:0]      wire_type;
        logic [VAL_W-1:0]     field_value;
        logic [OUT_OFF_W-1:0] payload_offset;
        logic [OUT_OFF_W-1:0] payload_length;
        t_status              field_status;
        logic                 message_done;
    } t_result;

    // clamp a 64-bit count to the offset range
    function automatic logic [OFF_W-1:0] sat_off(input logic [VAL_W-1:0] v);
        logic [OFF_W-1:0] r;
        r = (|v[VAL_W-1:OFF_W]) ? OFF_MAX : v[OFF_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/pbfs_in_reg.sv]
// Input register stage of the protobuf field scanner: holds one input byte.
// Depends on pbfs_pkg.
`default_nettype none

module pbfs_in_reg
    import pbfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    input  wire logic                  i_take,
    output logic                       o_valid,
    output logic [7:0]                 o_byte,
    output logic                       o_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    assign s_axis_tready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte <= s_axis_tdata[7:0];
            r_last <= s_axis_tlast;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

`default_nettype wire

[rtl/core/pbfs_decode.sv]
// Wire-format decode state and next-state logic of the protobuf field scanner.
// Depends on pbfs_pkg.
`default_nettype none

module pbfs_decode
    import pbfs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output logic            o_emit,
    output t_result         o_res
);

    t_phase             r_phase,  n_phase;
    logic [SHIFT_W-1:0] r_shift,  n_shift;
    logic [VAL_W-1:0]   r_acc,    n_acc;
    logic [KEY_W-1:0]   r_held,   n_held;
    logic [OFF_W-1:0]   r_off,    n_off;
    logic [VAL_W-1:0]   r_rem,    n_rem;
    logic [OFF_W-1:0]   r_pstart, n_pstart;

    logic [6:0]         shamt;
    logic [VAL_W-1:0]   grp;
    logic [VAL_W-1:0]   var_acc;
    logic [VAL_W-1:0]   fix_acc;
    logic [VAL_W-1:0]   rem_dec;
    logic               more;
    t_phase             ph_k;
    logic [KEY_W-1:0]   e_key;
    logic [VAL_W-1:0]   e_val;
    logic [OFF_W-1:0]   e_off;
    logic [OFF_W-1:0]   e_len;
    t_status            e_st;
    logic               emit;
    logic               start_key;

    assign more    = |(i_byte & MORE_MASK);
    assign shamt   = ({3'b000, r_shift} << 3) - {3'b000, r_shift};
    assign grp     = VAL_W'(i_byte & GROUP_MASK) << shamt;
    assign var_acc = (r_shift < VARINT_GROUPS) ? (r_acc | grp) : r_acc;
    assign fix_acc = r_acc | (VAL_W'(i_byte) << {r_shift[2:0], 3'b000});
    assign rem_dec = r_rem - VAL_W'(r_rem != '0);
    assign ph_k    = (r_phase == PH_VAL || r_phase == PH_LEN) ? r_phase : PH_KEY;

    always_comb begin
        n_phase   = r_phase;
        n_shift   = r_shift;
        n_acc     = r_acc;
        n_held    = r_held;
        n_rem     = r_rem;
        n_pstart  = r_pstart;
        n_off     = (r_off == OFF_MAX) ? r_off : r_off + 1'b1;
        emit      = 1'b0;
        start_key = 1'b0;
        e_key     = '0;
        e_val     = '0;
        e_off     = '0;
        e_len     = '0;
        e_st      = ST_OK;

        unique case (r_phase)
            PH_FIX: begin
                n_acc   = fix_acc;
                n_shift = r_shift + 1'b1;
                n_rem   = rem_dec;
                if (rem_dec == '0) begin
                    emit      = 1'b1;
                    e_key     = r_held;
                    e_val     = fix_acc;
                    start_key = 1'b1;
                end else if (i_last) begin
                    emit  = 1'b1;
                    e_key = r_held;
                    e_st  = ST_TRUNC;
                end
            end
            PH_SKIP: begin
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    emit      = 1'b1;
                    e_key     = r_held;
                    e_off     = r_pstart;
                    e_len     = sat_off(r_acc);
                    start_key = 1'b1;
                end else if (i_last) begin
                    emit  = 1'b1;
                    e_key = r_held;
                    e_off = r_pstart;
                    e_len = sat_off(r_acc);
                    e_st  = ST_TRUNC;
                end
            end
            default: begin
                n_phase = ph_k;
                n_shift = (r_shift < VARINT_GROUPS) ? r_shift + 1'b1 : r_shift;
                if (more) begin
                    n_acc = var_acc;
                    if (i_last) begin
                        emit  = 1'b1;
                        e_key = (ph_k == PH_KEY) ? '0 : r_held;
                        e_st  = ST_TRUNC;
                    end
                end else begin
                    n_acc   = '0;
                    n_shift = '0;
                    priority case (ph_k)
                        PH_KEY: begin
                            n_held = var_acc;
                            priority case (var_acc[WT_W-1:0])
                                WT_VARINT: n_phase = PH_VAL;
                                WT_FIX64: begin
                                    n_phase = PH_FIX;
                                    n_rem   = FIX64_BYTES;
                                end
                                WT_LEN:    n_phase = PH_LEN;
                                WT_FIX32: begin
                                    n_phase = PH_FIX;
                                    n_rem   = FIX32_BYTES;
                                end
                                default: begin
                                    emit      = 1'b1;
                                    e_key     = var_acc;
                                    e_st      = ST_UNSUP;
                                    start_key = 1'b1;
                                end
                            endcase
                            if (!emit && i_last) begin
                                emit  = 1'b1;
                                e_key = var_acc;
                                e_st  = ST_TRUNC;
                            end
                        end
                        PH_VAL: begin
                            emit      = 1'b1;
                            e_key     = r_held;
                            e_val     = var_acc;
                            start_key = 1'b1;
                        end
                        default: begin
                            n_pstart = n_off;
                            if (var_acc == '0) begin
                                emit      = 1'b1;
                                e_key     = r_held;
                                e_off     = n_off;
                                start_key = 1'b1;
                            end else begin
                                n_phase = PH_SKIP;
                                n_rem   = var_acc;
                                n_acc   = var_acc;
                                if (i_last) begin
                                    emit  = 1'b1;
                                    e_key = r_held;
                                    e_off = n_off;
                                    e_len = sat_off(var_acc);
                                    e_st  = ST_TRUNC;
                                end
                            end
                        end
                    endcase
                end
            end
        endcase

        if (start_key) begin
            n_phase = PH_KEY;
            n_shift = '0;
            n_acc   = '0;
            n_rem   = '0;
        end
        if (i_last) begin
            n_phase  = PH_KEY;
            n_shift  = '0;
            n_acc    = '0;
            n_rem    = '0;
            n_held   = '0;
            n_off    = '0;
            n_pstart = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_KEY;
            r_shift  <= '0;
            r_acc    <= '0;
            r_held   <= '0;
            r_off    <= '0;
            r_rem    <= '0;
            r_pstart <= '0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_shift  <= n_shift;
            r_acc    <= n_acc;
            r_held   <= n_held;
            r_off    <= n_off;
            r_rem    <= n_rem;
            r_pstart <= n_pstart;
        end
    end

    assign o_emit               = emit;
    assign o_res.field_number   = e_key[KEY_W-1:WT_W];
    assign o_res.wire_type      = e_key[WT_W-1:0];
    assign o_res.field_value    = e_val;
    assign o_res.payload_offset = OUT_OFF_W'(e_off);
    assign o_res.payload_length = OUT_OFF_W'(e_len);
    assign o_res.field_status   = e_st;
    assign o_res.message_done   = i_last;

endmodule

`default_nettype wire

[rtl/core/pbfs_out_reg.sv]
// Result register of the protobuf field scanner, master side of the stream.
// Depends on pbfs_pkg.
`default_nettype none

module pbfs_out_reg
    import pbfs_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_take,
    input  wire logic                    i_emit,
    input  wire t_result                 i_res,
    output logic                         o_free,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata,   // field_number, field_value,
                                                         // payload_offset, payload_length
    output logic [OUT_TUSER_W-1:0]       m_axis_tuser,   // wire_type, field_status
    output logic                         m_axis_tlast    // message_done
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= i_emit;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_emit) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {3'b000, r_res.payload_length, r_res.payload_offset,
                            r_res.field_value, r_res.field_number};
    assign m_axis_tuser  = {r_res.field_status, r_res.wire_type};
    assign m_axis_tlast  = r_res.message_done;

endmodule

`default_nettype wire

[rtl/core/protobuf_field_scanner.sv]
// An accepted byte is registered in pbfs_in_reg, decoded, and its field request registered in pbfs_out_reg.
// Throughput: one byte per cycle while the master side is not stalled by m_axis_tready.
// Reset: i_rst_n synchronous, active low; clears the decode state and both valids.
// Top level of the protobuf field scanner; instantiates pbfs_in_reg,
// pbfs_decode and pbfs_out_reg. Depends on pbfs_pkg.
`default_nettype none

module protobuf_field_scanner
    import pbfs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // data_byte
    input  wire logic                   s_axis_tlast,   // end_of_message
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // field_number[60:0], field_value,
                                                        // payload_offset, payload_length
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser,   // wire_type[2:0], field_status
    output logic                        m_axis_tlast    // message_done
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_free;
    logic       take;
    logic       emit;
    t_result    res;

    assign take = in_valid && out_free;

    pbfs_in_reg u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_take        (take),
        .o_valid       (in_valid),
        .o_byte        (in_byte),
        .o_last        (in_last)
    );

    pbfs_decode u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (in_byte),
        .i_last  (in_last),
        .o_emit  (emit),
        .o_res   (res)
    );

    pbfs_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_emit        (emit),
        .i_res         (res),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[4:3] == ST_TRUNC |-> m_axis_tlast)
        else $error("truncated field without message end");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[4:3] != 2'd3)
        else $error("invalid field status");

    a_unsup_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[4:3] == ST_UNSUP |->
            m_axis_tuser[2:0] != WT_VARINT && m_axis_tuser[2:0] != WT_FIX64 &&
            m_axis_tuser[2:0] != WT_LEN && m_axis_tuser[2:0] != WT_FIX32)
        else $error("supported wire type flagged unsupported");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[4:3] != ST_OK |-> m_axis_tdata[124:61] == '0)
        else $error("nonzero value on incomplete field");

endmodule

`default_nettype wire
